/* design/whte_pkg.sv */
// ----------------------------------------------------------------------------
// whte_pkg
// Shared types and constants of the word hash table engine: transaction
// payloads, operation and status codes, controller command and status groups.
// ----------------------------------------------------------------------------
package whte_pkg;

    localparam int OP_W        = 2;
    localparam int BYTE_W      = 8;
    localparam int HASH_PORT_W = 32;
    localparam int SLOT_PORT_W = 10;
    localparam int STATUS_W    = 3;
    localparam int USED_W      = 11;

    // djb2 seed and multiplier
    localparam int ACC_INIT = 5381;
    localparam int ACC_MULT = 33;

    typedef enum logic [OP_W-1:0] {
        OP_KEY_BYTE = 2'd0,
        OP_LOOKUP   = 2'd1,
        OP_PUSH     = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_FULL      = 3'd2,
        ST_ADDED     = 3'd3,
        ST_DUPLICATE = 3'd4,
        ST_LISTFULL  = 3'd5
    } t_status;

    // what an accepted transaction starts
    typedef enum logic [1:0] {
        K_NONE,
        K_LOOKUP,
        K_PUSH
    } t_kind;

    typedef struct packed {
        logic [OP_W-1:0]        operation;
        logic [BYTE_W-1:0]      key_byte;
        logic                   last;
        logic [HASH_PORT_W-1:0] hash;
        logic [SLOT_PORT_W-1:0] slot;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [SLOT_PORT_W-1:0] result_slot;
        logic [HASH_PORT_W-1:0] result_hash;
        logic [USED_W-1:0]      used_count;
    } t_out;

    typedef struct packed {
        logic    clr_wr;
        logic    load;
        logic    mod_start;
        logic    probe_init;
        logic    slot_rd;
        logic    probe_adv;
        logic    ins_wr;
        logic    push_load;
        logic    scan_rd;
        logic    scan_adv;
        logic    push_wr;
        logic    res_set;
        t_status res_code;
        logic    emit;
    } t_cmd;

    typedef struct packed {
        t_kind in_kind;
        logic  clr_done;
        logic  mod_done;
        logic  occ;
        logic  hit;
        logic  probe_last;
        logic  cnt_zero;
        logic  fl_hit;
        logic  scan_last;
        logic  list_full;
        logic  out_free;
    } t_sts;

endpackage

/* design/word_hash_table_engine_core.sv */
// ----------------------------------------------------------------------------
// word_hash_table_engine_core
// Find-or-insert hash table with linear probing and per-slot follower sets.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A key byte that is not the last is accepted
// and gives no result. A lookup (last key byte or given hash) passes through
// acceptance, the hash remainder (a bit select when SLOTS is a power of two,
// otherwise the bit-serial remainder unit), a slot memory read and compare
// per probed slot, and the hand-off of the result to the output register. A
// push passes through acceptance, a read of the slot entry, a list memory
// read and compare per follower already stored, the append and the result
// hand-off; the single read port of each memory is why each read and its
// compare are separate steps. After reset the slot memory is swept once,
// one slot per cycle, with o_in_stall held.
module word_hash_table_engine_core #(
    parameter int SLOTS     = 1024,
    parameter int FOLLOWERS = 16,
    parameter int HASH_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  whte_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output whte_pkg::t_out o_out_data
);

    whte_pkg::t_cmd cmd;
    whte_pkg::t_sts sts;

    whte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    whte_dp #(
        .SLOTS     (SLOTS),
        .FOLLOWERS (FOLLOWERS),
        .HASH_BITS (HASH_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

/* design/whte_mod.sv */
// ----------------------------------------------------------------------------
// whte_mod
// Remainder of a hash by the slot count: a plain bit select for a power-of-two
// slot count, otherwise a restoring remainder unit taking one bit per cycle.
// ----------------------------------------------------------------------------
module whte_mod #(
    parameter int SLOTS     = 1024,
    parameter int HASH_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [HASH_BITS-1:0]     i_value,
    output logic                     o_done,
    output logic [$clog2(SLOTS)-1:0] o_rem
);

    localparam int  SLOT_W = $clog2(SLOTS);
    localparam bit  POW2   = (SLOTS & (SLOTS - 1)) == 0;

    if (POW2) begin : g_pow2
        logic              r_done;
        logic [SLOT_W-1:0] r_rem;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_done <= 1'b0;
            end else begin
                r_done <= i_start;
            end
            if (i_start) begin
                r_rem <= i_value[SLOT_W-1:0];
            end
        end

        assign o_done = r_done;
        assign o_rem  = r_rem;
    end else begin : g_div
        localparam int CNT_W = $clog2(HASH_BITS);

        logic                 r_busy;
        logic                 r_done;
        logic [CNT_W-1:0]     r_cnt;
        logic [HASH_BITS-1:0] r_val;
        logic [SLOT_W-1:0]    r_rem;
        logic [SLOT_W:0]      trial;

        always_comb begin
            trial = {r_rem, r_val[HASH_BITS-1]};
            if (trial >= (SLOT_W + 1)'(SLOTS)) begin
                trial = trial - (SLOT_W + 1)'(SLOTS);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_busy <= 1'b0;
                r_done <= 1'b0;
            end else begin
                r_done <= 1'b0;
                if (i_start) begin
                    r_busy <= 1'b1;
                end else if (r_busy && r_cnt == CNT_W'(HASH_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
            if (i_start) begin
                r_val <= i_value;
                r_rem <= '0;
                r_cnt <= '0;
            end else if (r_busy) begin
                r_val <= r_val << 1;
                r_rem <= trial[SLOT_W-1:0];
                r_cnt <= r_cnt + 1'b1;
            end
        end

        assign o_done = r_done;
        assign o_rem  = r_rem;
    end

endmodule

/* design/whte_dp.sv */
// ----------------------------------------------------------------------------
// whte_dp
// Datapath: djb2 accumulator, slot memory (occupancy, follower count, hash),
// follower list memory, probe and scan counters, result staging and output
// register.
// ----------------------------------------------------------------------------
module whte_dp #(
    parameter int SLOTS     = 1024,
    parameter int FOLLOWERS = 16,
    parameter int HASH_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  whte_pkg::t_in  i_in_data,
    input  whte_pkg::t_cmd i_cmd,
    output whte_pkg::t_sts o_sts,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output whte_pkg::t_out o_out_data
);

    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(FOLLOWERS + 1);
    localparam int FL_DEPTH = SLOTS * FOLLOWERS;
    localparam int FL_AW    = $clog2(FL_DEPTH);
    localparam int CMP_W    = SLOT_W + whte_pkg::SLOT_PORT_W;
    localparam int PCNT_W   = SLOT_W + 1;

    typedef struct packed {
        logic                 occ;
        logic [CNT_W-1:0]     cnt;
        logic [HASH_BITS-1:0] hash;
    } t_sword;

    t_sword               r_slot_mem [SLOTS];
    logic [HASH_BITS-1:0] r_fl_mem [FL_DEPTH];

    logic [HASH_BITS-1:0]        r_acc;
    logic [HASH_BITS-1:0]        r_hash;
    logic [SLOT_W-1:0]           r_idx;
    logic [SLOT_W-1:0]           r_clr;
    logic [PCNT_W-1:0]           r_pcnt;
    logic [FL_AW-1:0]            r_base;
    logic [CNT_W-1:0]            r_n;
    logic [CNT_W-1:0]            r_i;
    logic [whte_pkg::USED_W-1:0] r_used;
    whte_pkg::t_status           r_code;
    t_sword                      r_srd;
    logic [HASH_BITS-1:0]        r_frd;
    logic                        r_out_valid;
    whte_pkg::t_out              r_out;

    logic [HASH_BITS-1:0] acc_next;
    logic [HASH_BITS-1:0] in_hash;
    logic                 in_slot_ok;
    logic [SLOT_W-1:0]    in_slot_idx;
    whte_pkg::t_kind      in_kind;
    logic                 mod_done;
    logic [SLOT_W-1:0]    mod_rem;
    logic [CNT_W-1:0]     cnt_cap;
    logic                 swr_en;
    logic [SLOT_W-1:0]    swr_addr;
    t_sword               swr_data;
    logic [FL_AW-1:0]     fl_raddr;
    logic [FL_AW-1:0]     fl_waddr;
    logic                 out_free;

    always_comb begin
        acc_next = r_acc * HASH_BITS'(whte_pkg::ACC_MULT)
                 + HASH_BITS'(i_in_data.key_byte);
        if (i_in_data.operation == whte_pkg::OP_KEY_BYTE) begin
            in_hash = acc_next;
        end else begin
            in_hash = HASH_BITS'(i_in_data.hash);
        end
        in_slot_ok  = CMP_W'(i_in_data.slot) < CMP_W'(SLOTS);
        in_slot_idx = SLOT_W'(i_in_data.slot);
        case (i_in_data.operation)
            whte_pkg::OP_KEY_BYTE: in_kind = i_in_data.last ? whte_pkg::K_LOOKUP
                                                            : whte_pkg::K_NONE;
            whte_pkg::OP_LOOKUP:   in_kind = whte_pkg::K_LOOKUP;
            whte_pkg::OP_PUSH:     in_kind = in_slot_ok ? whte_pkg::K_PUSH
                                                        : whte_pkg::K_NONE;
            default:               in_kind = whte_pkg::K_NONE;
        endcase
    end

    whte_mod #(
        .SLOTS     (SLOTS),
        .HASH_BITS (HASH_BITS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mod_start),
        .i_value (in_hash),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    always_comb begin
        if (r_srd.cnt > CNT_W'(FOLLOWERS)) begin
            cnt_cap = CNT_W'(FOLLOWERS);
        end else begin
            cnt_cap = r_srd.cnt;
        end
        fl_raddr = r_base + FL_AW'(r_i);
        fl_waddr = r_base + FL_AW'(r_n);
        out_free = !r_out_valid || !i_out_stall;

        swr_en   = i_cmd.clr_wr || i_cmd.ins_wr || i_cmd.push_wr;
        swr_addr = r_idx;
        swr_data = '0;
        if (i_cmd.clr_wr) begin
            swr_addr = r_clr;
        end else if (i_cmd.ins_wr) begin
            swr_data.occ  = 1'b1;
            swr_data.hash = r_hash;
        end else if (i_cmd.push_wr) begin
            swr_data.occ  = 1'b1;
            swr_data.cnt  = r_n + 1'b1;
            swr_data.hash = r_srd.hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (swr_en) begin
            r_slot_mem[swr_addr] <= swr_data;
        end
        if (i_cmd.slot_rd) begin
            r_srd <= r_slot_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_wr) begin
            r_fl_mem[fl_waddr] <= r_hash;
        end
        if (i_cmd.scan_rd) begin
            r_frd <= r_fl_mem[fl_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= HASH_BITS'(whte_pkg::ACC_INIT);
            r_used      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && i_in_data.operation == whte_pkg::OP_KEY_BYTE) begin
                r_acc <= i_in_data.last ? HASH_BITS'(whte_pkg::ACC_INIT) : acc_next;
            end
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.ins_wr) begin
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hash <= in_hash;
            r_idx  <= in_slot_idx;
            r_base <= FL_AW'(in_slot_idx) * FL_AW'(FOLLOWERS);
        end
        if (i_cmd.probe_init) begin
            r_idx  <= mod_rem;
            r_pcnt <= '0;
        end
        if (i_cmd.probe_adv) begin
            r_pcnt <= r_pcnt + 1'b1;
            r_idx  <= (r_idx == SLOT_W'(SLOTS - 1)) ? '0 : r_idx + 1'b1;
        end
        if (i_cmd.push_load) begin
            r_n <= cnt_cap;
            r_i <= '0;
        end
        if (i_cmd.scan_adv) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.res_set) begin
            r_code <= i_cmd.res_code;
        end
        if (i_cmd.emit) begin
            r_out.status      <= r_code;
            r_out.result_slot <= (r_code == whte_pkg::ST_FULL)
                               ? '0 : whte_pkg::SLOT_PORT_W'(r_idx);
            r_out.result_hash <= whte_pkg::HASH_PORT_W'(r_hash);
            r_out.used_count  <= r_used;
        end
    end

    always_comb begin
        o_sts.in_kind    = in_kind;
        o_sts.clr_done   = r_clr == SLOT_W'(SLOTS - 1);
        o_sts.mod_done   = mod_done;
        o_sts.occ        = r_srd.occ;
        o_sts.hit        = r_srd.hash == r_hash;
        o_sts.probe_last = r_pcnt == PCNT_W'(SLOTS - 1);
        o_sts.cnt_zero   = r_srd.cnt == '0;
        o_sts.fl_hit     = r_frd == r_hash;
        o_sts.scan_last  = (r_i + 1'b1) == r_n;
        o_sts.list_full  = r_n == CNT_W'(FOLLOWERS);
        o_sts.out_free   = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_scan_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_rd |-> r_i < r_n)
        else $error("follower scan past stored count");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_wr |-> r_n < CNT_W'(FOLLOWERS))
        else $error("follower write into a full list");

    a_insert_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_wr |-> !r_srd.occ)
        else $error("insert into an occupied slot");

endmodule

/* design/whte_ctrl.sv */
// ----------------------------------------------------------------------------
// whte_ctrl
// Controller: clearing pass after reset, input acceptance, remainder wait,
// linear probe, follower scan and result hand-off.
// ----------------------------------------------------------------------------
module whte_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  whte_pkg::t_sts i_sts,
    output whte_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_PUSH_RD,
        S_PUSH_CHK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_PUSH_END,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;
    logic   accept;

    assign accept = i_in_valid && !r_in_stall;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.res_code = whte_pkg::ST_FOUND;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    case (i_sts.in_kind)
                        whte_pkg::K_LOOKUP: begin
                            o_cmd.mod_start = 1'b1;
                            n_state         = S_MOD;
                        end
                        whte_pkg::K_PUSH: begin
                            n_state = S_PUSH_RD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_MOD: begin
                if (i_sts.mod_done) begin
                    o_cmd.probe_init = 1'b1;
                    n_state          = S_PROBE_RD;
                end
            end
            S_PROBE_RD: begin
                o_cmd.slot_rd = 1'b1;
                n_state       = S_PROBE_CHK;
            end
            S_PROBE_CHK: begin
                if (!i_sts.occ) begin
                    o_cmd.ins_wr   = 1'b1;
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = whte_pkg::ST_INSERTED;
                    n_state        = S_EMIT;
                end else if (i_sts.hit) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = whte_pkg::ST_FOUND;
                    n_state        = S_EMIT;
                end else if (i_sts.probe_last) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = whte_pkg::ST_FULL;
                    n_state        = S_EMIT;
                end else begin
                    o_cmd.probe_adv = 1'b1;
                    n_state         = S_PROBE_RD;
                end
            end
            S_PUSH_RD: begin
                o_cmd.slot_rd = 1'b1;
                n_state       = S_PUSH_CHK;
            end
            S_PUSH_CHK: begin
                o_cmd.push_load = 1'b1;
                n_state         = i_sts.cnt_zero ? S_PUSH_END : S_SCAN_RD;
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_sts.fl_hit) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = whte_pkg::ST_DUPLICATE;
                    n_state        = S_EMIT;
                end else if (i_sts.scan_last) begin
                    n_state = S_PUSH_END;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                    n_state        = S_SCAN_RD;
                end
            end
            S_PUSH_END: begin
                o_cmd.res_set = 1'b1;
                if (i_sts.list_full) begin
                    o_cmd.res_code = whte_pkg::ST_LISTFULL;
                end else begin
                    o_cmd.push_wr  = 1'b1;
                    o_cmd.res_code = whte_pkg::ST_ADDED;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_in_stall <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_stall <= n_state != S_IDLE;
        end
    end

    assign o_in_stall = r_in_stall;

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> r_state == S_IDLE)
        else $error("transaction accepted outside idle");

    a_mod_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.mod_done |-> r_state == S_MOD)
        else $error("remainder done while not waiting for it");

endmodule
